// ----- hw/rtl/dewr_pkg.sv -----
// ----------------------------------------------------------------------------
// dewr_pkg
// Request codes, status codes and the response control bundle shared by the
// double-ended queue modules.
// ----------------------------------------------------------------------------
package dewr_pkg;

  typedef enum logic [2:0] {
    REQ_ADD_FRONT = 3'd0,
    REQ_ADD_BACK  = 3'd1,
    REQ_REM_FRONT = 3'd2,
    REQ_REM_BACK  = 3'd3,
    REQ_REVERSE   = 3'd4,
    REQ_STATUS    = 3'd5
  } req_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic    done;
    status_t status;
    logic    is_empty;
    logic    reversed;
  } rsp_t;

endpackage

// ----- hw/rtl/double_ended_queue_with_reverse.sv -----
// ----------------------------------------------------------------------------
// double_ended_queue_with_reverse
// Bounded double-ended queue on a ring memory with head pointer, word count
// and a direction flag; reverse only toggles the flag.
//
//   channel   | handshake          | signals
//   ----------+--------------------+-------------------------------------------
//   request   | start / busy       | req_type, value
//   response  | done (strobe)      | status, front_value, back_value,
//             |                    | is_empty, count
//
// A request transfers at the edge where start is high and busy is low; busy
// is high only during reset, so one request per cycle is taken. The memory
// is written and both ends are read in the transfer cycle (write forwarded to
// the read ports), and the response appears on done in the following cycle.
// Reset clears head, count and direction; the memory needs no clearing.
// The receiver cannot stall; every response is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module double_ended_queue_with_reverse #(
  parameter int DEPTH      = 64,
  parameter int WORD_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  req_type,
  input  logic [63:0] value,
  output logic        done,
  output logic [1:0]  status,
  output logic [63:0] front_value,
  output logic [63:0] back_value,
  output logic        is_empty,
  output logic [6:0]  count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic                  accept;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [WORD_WIDTH-1:0] wr_data;
  logic [AW-1:0]         rd_first;
  logic [AW-1:0]         rd_last;
  logic [WORD_WIDTH-1:0] first_data;
  logic [WORD_WIDTH-1:0] last_data;
  dewr_pkg::rsp_t        rsp;
  logic [CW-1:0]         rsp_count;

  assign busy   = rst;
  assign accept = start & ~busy;

  dewr_ctrl #(
    .DEPTH      (DEPTH),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .req_type  (req_type),
    .value     (value),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_first  (rd_first),
    .rd_last   (rd_last),
    .rsp       (rsp),
    .rsp_count (rsp_count)
  );

  dewr_store #(
    .DEPTH      (DEPTH),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_store (
    .clk        (clk),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_first   (rd_first),
    .rd_last    (rd_last),
    .first_data (first_data),
    .last_data  (last_data)
  );

  // reversed: logical front is the physical last word
  always_comb begin
    front_value = '0;
    back_value  = '0;
    if (!rsp.is_empty) begin
      front_value = 64'(rsp.reversed ? last_data : first_data);
      back_value  = 64'(rsp.reversed ? first_data : last_data);
    end
  end

  assign done     = rsp.done;
  assign status   = rsp.status;
  assign is_empty = rsp.is_empty;
  assign count    = 7'(rsp_count);

endmodule

// ----- hw/rtl/dewr_store.sv -----
// ----------------------------------------------------------------------------
// dewr_store
// Ring word memory: one write port and two read ports with registered read
// data; a write to the address being read in the same cycle is forwarded.
// ----------------------------------------------------------------------------
module dewr_store #(
  parameter int DEPTH      = 64,
  parameter int WORD_WIDTH = 64,
  localparam int AW        = $clog2(DEPTH)
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  logic [WORD_WIDTH-1:0] wr_data,
  input  logic [AW-1:0]         rd_first,
  input  logic [AW-1:0]         rd_last,
  output logic [WORD_WIDTH-1:0] first_data,
  output logic [WORD_WIDTH-1:0] last_data
);

  logic [WORD_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read ports see the word written in the same cycle
  always_ff @(posedge clk) begin
    if (wr_en && wr_addr == rd_first) begin
      first_data <= wr_data;
    end else begin
      first_data <= mem[rd_first];
    end
    if (wr_en && wr_addr == rd_last) begin
      last_data <= wr_data;
    end else begin
      last_data <= mem[rd_last];
    end
  end

endmodule

// ----- hw/rtl/dewr_ctrl.sv -----
// ----------------------------------------------------------------------------
// dewr_ctrl
// Head pointer, word count and direction flag of the ring; decodes each
// request, drives the memory write and the read addresses of both ends.
// ----------------------------------------------------------------------------
module dewr_ctrl #(
  parameter int DEPTH      = 64,
  parameter int WORD_WIDTH = 64,
  localparam int AW        = $clog2(DEPTH),
  localparam int CW        = $clog2(DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic [2:0]            req_type,
  input  logic [63:0]           value,
  output logic                  wr_en,
  output logic [AW-1:0]         wr_addr,
  output logic [WORD_WIDTH-1:0] wr_data,
  output logic [AW-1:0]         rd_first,
  output logic [AW-1:0]         rd_last,
  output dewr_pkg::rsp_t        rsp,
  output logic [CW-1:0]         rsp_count
);

  localparam int SW = CW + 1;

  logic [AW-1:0] head;
  logic [AW-1:0] head_next;
  logic [CW-1:0] cnt;
  logic [CW-1:0] cnt_next;
  logic          rev;
  logic          rev_next;
  dewr_pkg::status_t st;

  logic          full;
  logic          empty;
  logic [AW-1:0] head_dec;
  logic [AW-1:0] head_inc;
  logic [SW-1:0] tail_sum;
  logic [AW-1:0] tail;
  logic [SW-1:0] last_sum;

  assign full  = (cnt == CW'(DEPTH));
  assign empty = (cnt == '0);

  assign head_dec = (head == '0) ? AW'(DEPTH - 1) : head - AW'(1);
  assign head_inc = (head == AW'(DEPTH - 1)) ? '0 : head + AW'(1);

  // slot just past the last held word
  assign tail_sum = SW'(head) + SW'(cnt);
  assign tail     = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH)) : AW'(tail_sum);

  assign wr_data = value[WORD_WIDTH-1:0];

  always_comb begin
    head_next = head;
    cnt_next  = cnt;
    rev_next  = rev;
    wr_en     = 1'b0;
    wr_addr   = tail;
    st        = dewr_pkg::ST_OK;
    if (accept) begin
      unique case (req_type) inside
        dewr_pkg::REQ_ADD_FRONT, dewr_pkg::REQ_ADD_BACK: begin
          if (full) begin
            st = dewr_pkg::ST_FULL;
          end else begin
            wr_en    = 1'b1;
            cnt_next = cnt + CW'(1);
            // logical front maps to the physical first word unless reversed
            if ((req_type == dewr_pkg::REQ_ADD_FRONT) != rev) begin
              head_next = head_dec;
              wr_addr   = head_dec;
            end
          end
        end
        dewr_pkg::REQ_REM_FRONT, dewr_pkg::REQ_REM_BACK: begin
          if (empty) begin
            st = dewr_pkg::ST_EMPTY;
          end else begin
            cnt_next = cnt - CW'(1);
            if ((req_type == dewr_pkg::REQ_REM_FRONT) != rev) begin
              head_next = head_inc;
            end
          end
        end
        dewr_pkg::REQ_REVERSE: begin
          rev_next = ~rev;
        end
        default: begin
          st = dewr_pkg::ST_OK;
        end
      endcase
    end
  end

  // both ends after the update; don't care when the queue ends up empty
  assign last_sum = SW'(head_next) + SW'(cnt_next) - SW'(1);
  assign rd_first = head_next;
  assign rd_last  = (last_sum >= SW'(DEPTH)) ? AW'(last_sum - SW'(DEPTH)) : AW'(last_sum);

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      cnt      <= '0;
      rev      <= 1'b0;
      rsp.done <= 1'b0;
    end else begin
      head     <= head_next;
      cnt      <= cnt_next;
      rev      <= rev_next;
      rsp.done <= accept;
    end
    rsp.status   <= st;
    rsp.is_empty <= (cnt_next == '0);
    rsp.reversed <= rev_next;
    rsp_count    <= cnt_next;
  end

endmodule
